// ----- rtl/lmslp_pkg.sv -----
// shared types and constants of the lms linear predictor
package lmslp_pkg;

	// geometry
	localparam int TAPS_DEF    = 4;
	localparam int SAMPLE_W    = 16;
	localparam int WEIGHT_W    = 32;
	localparam int RATE_W      = 16;
	localparam int SUM_W       = 32;
	localparam int ACC_W       = 52;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int OUT_TDATA_W = 72;

	// reset values of the configuration registers
	localparam logic [RATE_W-1:0]          RATE_RST    = 16'd66;
	localparam logic [SUM_W-1:0]           MIN_ERR_RST = 32'd655;
	localparam logic signed [WEIGHT_W-1:0] THR_RST     = 32'sh0100_0000;
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_RST  = 32'sh0000_0000;

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATE,
		REG_MIN_ERR,
		REG_INIT_THR,
		REG_INIT_W0,
		REG_INIT_W1,
		REG_INIT_W2,
		REG_INIT_W3
	} cfg_reg_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic mac_mul;
		logic mac_add;
		logic eval;
		logic sqr;
		logic upd_mul;
		logic upd_wr;
		logic thr_upd;
		logic finish;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic valid;
		logic train;
		logic out_busy;
	} dp_sts_t;

endpackage

// ----- rtl/lmslp_ctrl.sv -----
// sequencer of the lms linear predictor: walks mac, evaluation, update and output phases
module lmslp_ctrl #(
	parameter int TAPS  = lmslp_pkg::TAPS_DEF,
	parameter int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  lmslp_pkg::dp_sts_t   sts,
	output lmslp_pkg::dp_cmd_t   cmd,
	output logic [IDX_W-1:0]     mul_idx,
	output logic [IDX_W-1:0]     wr_idx
);
	import lmslp_pkg::*;

	localparam int CNT_W = $clog2(TAPS + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_EVAL,
		ST_SQR,
		ST_UPD,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_m1;

	// state and tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MAC;
						cnt_q   <= '0;
					end
				end
				ST_MAC: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_EVAL;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_EVAL: begin
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					cnt_q <= '0;
					if (sts.valid && sts.train) begin
						state_q <= ST_UPD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_UPD: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_DONE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd         = '0;
		cmd.load_in = (state_q == ST_IDLE) && s_tvalid;
		cmd.mac_mul = (state_q == ST_MAC) && (cnt_q != CNT_LAST);
		cmd.mac_add = (state_q == ST_MAC) && (cnt_q != '0);
		cmd.eval    = (state_q == ST_EVAL);
		cmd.sqr     = (state_q == ST_SQR);
		cmd.upd_mul = (state_q == ST_UPD) && (cnt_q != CNT_LAST);
		cmd.upd_wr  = (state_q == ST_UPD) && (cnt_q != '0);
		cmd.thr_upd = (state_q == ST_UPD) && (cnt_q == '0);
		cmd.finish  = (state_q == ST_DONE) && !sts.out_busy;
	end

	// tap addresses: product at cnt, write-back one behind
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign mul_idx  = cnt_q[IDX_W-1:0];
	assign wr_idx   = cnt_m1[IDX_W-1:0];
	assign s_tready = (state_q == ST_IDLE);

	// checks
	a_accept_starts_mac: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> (state_q == ST_MAC) && (cnt_q == '0))
		else $error("accepted item did not start the mac phase");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("tap counter out of range");

	a_upd_only_trained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (sts.valid && sts.train))
		else $error("weight update without a trained valid item");

	a_mac_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MAC) && (cnt_q == CNT_LAST)) |=> (state_q == ST_EVAL))
		else $error("mac phase did not end in evaluation");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == ST_IDLE) && !$past(sts.out_busy))
		else $error("finish taken while output register busy");

endmodule

// ----- rtl/lmslp_dp.sv -----
// datapath of the lms linear predictor: taps, weights, mac, update and output register
module lmslp_dp #(
	parameter int TAPS  = lmslp_pkg::TAPS_DEF,
	parameter int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [lmslp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lmslp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [lmslp_pkg::SAMPLE_W-1:0]        s_tdata,
	input  logic                                  s_tuser,
	input  logic                                  s_tlast,
	input  lmslp_pkg::dp_cmd_t                    cmd,
	input  logic [IDX_W-1:0]                      mul_idx,
	input  logic [IDX_W-1:0]                      wr_idx,
	output lmslp_pkg::dp_sts_t                    sts,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [lmslp_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                  m_tuser,
	output logic                                  m_tlast
);
	import lmslp_pkg::*;

	localparam int FILL_W = $clog2(TAPS + 1);
	localparam int MPROD_W = WEIGHT_W + SAMPLE_W;       // weight times tap
	localparam int RE_W = RATE_W + SAMPLE_W + 1;        // rate times error
	localparam int UPROD_W = RE_W + SAMPLE_W;           // rate*error times tap
	localparam int RND_W = ACC_W - 24;                  // acc rounded to q4.12
	localparam int SQ_W = 2 * SAMPLE_W - 1;
	localparam int HALF_W = 32 - 9;

	localparam logic signed [ACC_W-1:0]     ACC_HALF = ACC_W'(64'sd8388608);
	localparam logic signed [UPROD_W:0]     UPD_HALF = (UPROD_W + 1)'(64'sd32768);
	localparam logic signed [RE_W:0]        THR_HALF = (RE_W + 1)'(64'sd8);
	localparam logic signed [RND_W:0]       S16_MAX = (RND_W + 1)'(64'sd32767);
	localparam logic signed [RND_W:0]       S16_MIN = (RND_W + 1)'(-64'sd32768);
	localparam logic signed [WEIGHT_W+2:0]  W_MAX = (WEIGHT_W + 3)'(64'sd2147483647);
	localparam logic signed [WEIGHT_W+2:0]  W_MIN = (WEIGHT_W + 3)'(-64'sd2147483648);
	localparam logic [SUM_W-1:0]            SUM_MAX = '1;

	// configuration and adaptive state
	logic [RATE_W-1:0]          rate_q;
	logic [SUM_W-1:0]           min_err_q;
	logic signed [WEIGHT_W-1:0] w_q [TAPS];
	logic signed [WEIGHT_W-1:0] thr_q;
	logic signed [SAMPLE_W-1:0] win_q [TAPS];
	logic [FILL_W-1:0]          fill_q;
	logic [SUM_W-1:0]           sum_q;

	// per item working registers
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       train_q;
	logic                       last_q;
	logic signed [MPROD_W-1:0]  mprod_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] pred_q;
	logic signed [SAMPLE_W-1:0] err_q;
	logic [SQ_W-1:0]            sq_s1;
	logic signed [RE_W-1:0]     re_s1;
	logic signed [UPROD_W-1:0]  uprod_s1;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_pred_q;
	logic signed [SAMPLE_W-1:0] out_err_q;
	logic                       out_pv_q;
	logic [SUM_W-1:0]           out_sum_q;
	logic                       out_last_q;
	logic                       out_conv_q;

	// combinational terms
	logic                       valid;
	logic                       cfg_w_hit;
	logic [CFG_IDX_W-1:0]       cfg_w_k;
	logic signed [SAMPLE_W-1:0] win_sel;
	logic signed [WEIGHT_W-1:0] w_sel;
	logic signed [MPROD_W-1:0]  mprod;
	logic signed [ACC_W-1:0]    acc_rnd;
	logic signed [RND_W-1:0]    rnd;
	logic signed [RND_W:0]      rnd_x;
	logic signed [RND_W:0]      err_full;
	logic signed [SAMPLE_W-1:0] pred_sat;
	logic signed [SAMPLE_W-1:0] err_sat;
	logic signed [RE_W-1:0]     re_c;
	logic signed [2*SAMPLE_W-1:0] sq_c;
	logic signed [UPROD_W-1:0]  uprod;
	logic signed [UPROD_W:0]    d_sum;
	logic signed [UPROD_W-16:0] d_step;
	logic signed [WEIGHT_W+2:0] w_diff;
	logic signed [WEIGHT_W-1:0] w_new;
	logic signed [RE_W:0]       t_sum;
	logic signed [WEIGHT_W+2:0] t_next;
	logic signed [WEIGHT_W-1:0] thr_new;
	logic [31:0]                h_sum;
	logic [HALF_W-1:0]          half;
	logic [SUM_W:0]             sum_wide;
	logic [SUM_W-1:0]           sum_new;

	assign valid       = (fill_q >= FILL_W'(TAPS));
	assign sts.valid   = valid;
	assign sts.train   = train_q;
	assign sts.out_busy = out_valid_q && !m_tready;

	// configuration decode for weight writes
	assign cfg_w_hit = (cfg_index >= REG_INIT_W0) && (cfg_index <= REG_INIT_W3);
	assign cfg_w_k   = cfg_index - REG_INIT_W0;

	// multiplier operands and products
	assign win_sel = win_q[mul_idx];
	assign w_sel   = w_q[mul_idx];
	assign mprod   = w_sel * win_sel;
	assign uprod   = re_s1 * win_sel;

	// rounding of the accumulator to q4.12 and saturation
	assign acc_rnd  = acc_q + ACC_HALF;
	assign rnd      = acc_rnd[ACC_W-1:24];
	assign rnd_x    = (RND_W + 1)'(rnd);
	assign err_full = rnd_x - (RND_W + 1)'(sample_q);
	assign pred_sat = (rnd_x > S16_MAX) ? SAMPLE_W'(S16_MAX) :
		(rnd_x < S16_MIN) ? SAMPLE_W'(S16_MIN) : SAMPLE_W'(rnd_x);
	assign err_sat  = (err_full > S16_MAX) ? SAMPLE_W'(S16_MAX) :
		(err_full < S16_MIN) ? SAMPLE_W'(S16_MIN) : SAMPLE_W'(err_full);

	// rate times error and squared error
	assign re_c = $signed({1'b0, rate_q}) * err_q;
	assign sq_c = err_q * err_q;

	// weight step: round to q8.24, subtract, saturate
	assign d_sum  = (UPROD_W + 1)'(uprod_s1) + UPD_HALF;
	assign d_step = d_sum[UPROD_W:16];
	assign w_diff = (WEIGHT_W + 3)'(w_q[wr_idx]) - (WEIGHT_W + 3)'(d_step);
	assign w_new  = (w_diff > W_MAX) ? WEIGHT_W'(W_MAX) :
		(w_diff < W_MIN) ? WEIGHT_W'(W_MIN) : WEIGHT_W'(w_diff);

	// threshold step: round to q8.24, add, saturate
	assign t_sum   = (RE_W + 1)'(re_s1) + THR_HALF;
	assign t_next  = (WEIGHT_W + 3)'(thr_q) + (WEIGHT_W + 3)'($signed(t_sum[RE_W:4]));
	assign thr_new = (t_next > W_MAX) ? WEIGHT_W'(W_MAX) :
		(t_next < W_MIN) ? WEIGHT_W'(W_MIN) : WEIGHT_W'(t_next);

	// half squared error in q16.16, saturating epoch sum
	assign h_sum    = 32'(sq_s1) + 32'd256;
	assign half     = h_sum[31:9];
	assign sum_wide = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(half);
	assign sum_new  = !valid ? sum_q : (sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0]);

	// rate and convergence bound registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= RATE_RST;
			min_err_q <= MIN_ERR_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RATE:    rate_q    <= cfg_data[RATE_W-1:0];
				REG_MIN_ERR: min_err_q <= cfg_data[SUM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// weights and threshold: loaded by configuration, trained by updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RST;
			for (int j = 0; j < TAPS; j++) begin
				w_q[j] <= WEIGHT_RST;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_INIT_THR) begin
				thr_q <= $signed(cfg_data[WEIGHT_W-1:0]);
			end
			for (int j = 0; j < TAPS; j++) begin
				if (cfg_w_hit && (cfg_w_k == CFG_IDX_W'(j))) begin
					w_q[j] <= $signed(cfg_data[WEIGHT_W-1:0]);
				end
			end
		end else begin
			if (cmd.thr_upd) begin
				thr_q <= thr_new;
			end
			if (cmd.upd_wr) begin
				w_q[wr_idx] <= w_new;
			end
		end
	end

	// window, fill count and epoch sum: advanced once per item, cleared after the last item of an epoch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
			for (int j = 0; j < TAPS; j++) begin
				win_q[j] <= '0;
			end
		end else if (cmd.finish) begin
			if (last_q) begin
				fill_q <= '0;
				sum_q  <= '0;
				for (int j = 0; j < TAPS; j++) begin
					win_q[j] <= '0;
				end
			end else begin
				sum_q <= sum_new;
				if (!valid) begin
					fill_q <= fill_q + FILL_W'(1);
				end
				for (int j = 0; j < TAPS - 1; j++) begin
					win_q[j] <= win_q[j + 1];
				end
				win_q[TAPS - 1] <= sample_q;
			end
		end
	end

	// per item working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q <= $signed(s_tdata);
			train_q  <= s_tuser;
			last_q   <= s_tlast;
			acc_q    <= -(ACC_W'(thr_q) <<< 12);
		end else if (cmd.mac_add) begin
			acc_q <= acc_q + ACC_W'(mprod_s1);
		end
		if (cmd.mac_mul) begin
			mprod_s1 <= mprod;
		end
		if (cmd.eval) begin
			pred_q <= valid ? pred_sat : '0;
			err_q  <= valid ? err_sat : '0;
		end
		if (cmd.sqr) begin
			sq_s1 <= sq_c[SQ_W-1:0];
			re_s1 <= re_c;
		end
		if (cmd.upd_mul) begin
			uprod_s1 <= uprod;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_pred_q <= pred_q;
			out_err_q  <= err_q;
			out_pv_q   <= valid;
			out_sum_q  <= sum_new;
			out_last_q <= last_q;
			out_conv_q <= last_q && (sum_new <= min_err_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_conv_q, out_sum_q, out_err_q, out_pred_q};
	assign m_tuser  = out_pv_q;
	assign m_tlast  = out_last_q;

	// checks
	a_finish_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished item not presented");

	a_conv_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_conv_q) |-> out_last_q)
		else $error("converged flag outside epoch end");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_pv_q) |-> ((out_pred_q == '0) && (out_err_q == '0)))
		else $error("prediction reported while window not full");

endmodule

// ----- rtl/lms_linear_predictor.sv -----
// top level of the four-tap lms adaptive linear predictor
//
//  port group   dir  accepted when          contents
//  cfg_*        in   cfg_we high            register index, write data
//  s_*          in   s_tvalid & s_tready    sample; tuser train; tlast last_in_epoch
//  m_*          out  m_tvalid & m_tready    prediction, error, epoch sum, converged;
//                                           tuser prediction_valid; tlast epoch_done
//
//  an accepted item passes the mac, evaluation, squaring and, if trained and the
//  window is full, update phases before its result is loaded into the output register;
//  the next item is taken only once the last is finished; the taps are walked one per
//  cycle once for the dot product and once more for the weight update
//  reset clears window, fill count and epoch sum and loads the default weights
//  and threshold; no clearing pass is needed
//  a finished result waits in the output register; the next item is accepted
//  meanwhile and holds in its last phase only if the previous result is still unread
module lms_linear_predictor #(
	parameter int TAPS = lmslp_pkg::TAPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lmslp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lmslp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lmslp_pkg::SAMPLE_W-1:0]     s_tdata,   // [15:0] sample
	input  logic                               s_tuser,   // [0] train
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [15:0] prediction, [31:16] pred_error, [63:32] epoch_error, [64] converged
	output logic [lmslp_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                               m_tuser,   // [0] prediction_valid
	output logic                               m_tlast
);
	import lmslp_pkg::*;

	localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [IDX_W-1:0] mul_idx;
	logic [IDX_W-1:0] wr_idx;

	// sequencer
	lmslp_ctrl #(
		.TAPS  (TAPS),
		.IDX_W (IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.mul_idx  (mul_idx),
		.wr_idx   (wr_idx)
	);

	// arithmetic and state
	lmslp_dp #(
		.TAPS  (TAPS),
		.IDX_W (IDX_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cmd       (cmd),
		.mul_idx   (mul_idx),
		.wr_idx    (wr_idx),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the lms linear predictor
`timescale 1ns / 1ps

module testbench;
	import lmslp_pkg::*;

	localparam int TAPS = 4;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam longint I32_MAX = 64'sd2147483647;
	localparam longint I32_MIN = -I32_MAX - 1;
	localparam longint SUM_MAX = 64'h0000_0000_FFFF_FFFF;
	localparam longint Q12_MAX = 64'sd32767;
	localparam longint Q12_MIN = -64'sd32768;

	// one input item and one result item
	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		logic                train;
		logic                last;
	} lms_item_t;

	typedef struct {
		logic [SAMPLE_W-1:0] prediction;
		logic [SAMPLE_W-1:0] pred_error;
		logic                pred_valid;
		logic [SUM_W-1:0]    epoch_error;
		logic                epoch_done;
		logic                converged;
	} lms_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [SAMPLE_W-1:0]    s_tdata = '0;   // [15:0] sample
	logic                   s_tuser = 1'b0; // [0] train
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [15:0] prediction, [31:16] pred_error, [63:32] epoch_error, [64] converged
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;        // [0] prediction_valid
	logic                   m_tlast;

	lms_linear_predictor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state and register copies
	longint win [TAPS];
	longint wts [TAPS];
	longint thr_q824 = longint'(THR_RST);
	longint err_sum = 0;
	int     fill = 0;
	longint rate_q016 = longint'(RATE_RST);
	longint min_err_q1616 = longint'(MIN_ERR_RST);

	lms_item_t   sample_fifo[$];
	lms_result_t expected_out[$];
	lms_item_t   next_item;
	int          n_queued = 0;
	int          n_accepted = 0;
	int          n_fail = 0;
	int          cycles = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	bit          taken = 1'b0;

	initial begin
		for (int j = 0; j < TAPS; j++) begin
			win[j] = 0;
			wts[j] = longint'(WEIGHT_RST);
		end
	end

	function automatic longint round_shr(longint x, int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint x, longint lo, longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	// register write as seen by the predictor
	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_RATE:     rate_q016 = longint'(val[RATE_W-1:0]);
			REG_MIN_ERR:  min_err_q1616 = longint'(val);
			REG_INIT_THR: thr_q824 = $signed(val);
			REG_INIT_W0, REG_INIT_W1, REG_INIT_W2, REG_INIT_W3:
				wts[idx - REG_INIT_W0] = $signed(val);
			default: ;
		endcase
	endfunction

	// one lms step: predict, train, accumulate, shift window, clear at epoch end
	function automatic lms_result_t predict_sample(lms_item_t it);
		lms_result_t r;
		longint smp, acc, pred, err, re, half, sum;
		bit v;
		smp = $signed(it.sample);
		v = (fill >= TAPS);
		pred = 0;
		err = 0;
		if (v) begin
			acc = 0;
			for (int j = 0; j < TAPS; j++)
				acc += wts[j] * win[j];
			acc -= thr_q824 * 4096;
			pred = clip(round_shr(acc, 24), Q12_MIN, Q12_MAX);
			err = clip(round_shr(acc - smp * 16777216, 24), Q12_MIN, Q12_MAX);
			if (it.train) begin
				re = rate_q016 * err;
				for (int j = 0; j < TAPS; j++)
					wts[j] = clip(wts[j] - round_shr(re * win[j], 16), I32_MIN, I32_MAX);
				thr_q824 = clip(thr_q824 + round_shr(re, 4), I32_MIN, I32_MAX);
			end
			half = (err * err + 256) >>> 9;
			sum = err_sum + half;
			err_sum = (sum > SUM_MAX) ? SUM_MAX : sum;
		end
		for (int j = 0; j < TAPS - 1; j++)
			win[j] = win[j + 1];
		win[TAPS - 1] = smp;
		if (fill < TAPS)
			fill++;
		r.prediction = pred[SAMPLE_W-1:0];
		r.pred_error = err[SAMPLE_W-1:0];
		r.pred_valid = v;
		r.epoch_error = err_sum[SUM_W-1:0];
		r.epoch_done = it.last;
		r.converged = 1'b0;
		if (it.last) begin
			r.converged = (err_sum <= min_err_q1616);
			err_sum = 0;
			for (int j = 0; j < TAPS; j++)
				win[j] = 0;
			fill = 0;
		end
		return r;
	endfunction

	function automatic void cmp(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_fail++;
		end
	endfunction

	// input accept, prediction and result check
	always @(posedge clk) begin
		lms_item_t   acc_item;
		lms_result_t want;
		if (arst_n && s_tvalid && s_tready) begin
			acc_item.sample = s_tdata;
			acc_item.train = s_tuser;
			acc_item.last = s_tlast;
			expected_out.push_back(predict_sample(acc_item));
			n_accepted++;
			taken = 1'b1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_out.size() == 0) begin
				$error("result item with no expectation pending");
				n_fail++;
			end else begin
				want = expected_out.pop_front();
				cmp("prediction", want.prediction, m_tdata[15:0]);
				cmp("pred_error", want.pred_error, m_tdata[31:16]);
				cmp("prediction_valid", want.pred_valid, m_tuser);
				cmp("epoch_error", want.epoch_error, m_tdata[63:32]);
				cmp("epoch_done", want.epoch_done, m_tlast);
				cmp("converged", want.converged, m_tdata[64]);
			end
		end
	end

	// sender
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || taken)) begin
			taken = 1'b0;
			if (sample_fifo.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				next_item = sample_fifo.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_item.sample;
				s_tuser <= next_item.train;
				s_tlast <= next_item.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic push_item(logic [SAMPLE_W-1:0] smp, logic trn, logic lst);
		lms_item_t it;
		it.sample = smp;
		it.train = trn;
		it.last = lst;
		sample_fifo.push_back(it);
		n_queued++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		apply_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold off until every item is through and the block has settled
	task automatic wait_idle();
		do
			@(negedge clk);
		while (n_accepted != n_queued || expected_out.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_q824();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom();
			default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_bound();
		case ($urandom_range(3))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 32'h0010_0000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [15:0] rand_rate();
		case ($urandom_range(3))
			0: return 16'h0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 512));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0;
			3, 4, 5: return 16'($urandom_range(0, 8192)) - 16'd4096;
			default: return 16'($urandom());
		endcase
	endfunction

	// stimulus
	initial begin
		int cnt;
		int len;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 30;
		rx_idle_pct = 73;

		// defaults: window filling, extremes, single-item epoch on empty window
		push_item(16'h0000, 1'b1, 1'b0);
		push_item(16'h7FFF, 1'b1, 1'b0);
		push_item(16'h8000, 1'b0, 1'b0);
		push_item(16'h0001, 1'b1, 1'b0);
		push_item(16'hFFFF, 1'b1, 1'b0);
		push_item(16'h7FFF, 1'b0, 1'b1);
		push_item(16'h8000, 1'b1, 1'b1);
		wait_idle();

		// extreme registers, unused index, clamping of weights and threshold
		write_reg(REG_RATE, 32'h0000_FFFF);
		write_reg(REG_MIN_ERR, 32'hFFFF_FFFF);
		write_reg(REG_INIT_THR, 32'h8000_0000);
		write_reg(REG_INIT_W0, 32'h7FFF_FFFF);
		write_reg(REG_INIT_W1, 32'h8000_0000);
		write_reg(REG_INIT_W2, 32'h7FFF_FFFF);
		write_reg(REG_INIT_W3, 32'h8000_0000);
		write_reg(REG_UNUSED, 32'h1234_5678);
		for (int k = 0; k < 6; k++)
			push_item((k % 2) ? 16'h8000 : 16'h7FFF, 1'b1, 1'b0);
		push_item(16'h0000, 1'b1, 1'b0);
		push_item(16'h7FFF, 1'b1, 1'b1);
		wait_idle();

		// positive then negative saturation of prediction and error, zero rate
		write_reg(REG_RATE, 32'h0);
		write_reg(REG_MIN_ERR, 32'h0);
		write_reg(REG_INIT_THR, 32'h8000_0000);
		write_reg(REG_INIT_W0, 32'h7FFF_FFFF);
		write_reg(REG_INIT_W1, 32'h7FFF_FFFF);
		write_reg(REG_INIT_W2, 32'h7FFF_FFFF);
		write_reg(REG_INIT_W3, 32'h7FFF_FFFF);
		for (int k = 0; k < 4; k++)
			push_item(16'h7FFF, 1'b1, 1'b0);
		push_item(16'h8000, 1'b1, 1'b0);
		wait_idle();
		write_reg(REG_INIT_THR, 32'h7FFF_FFFF);
		write_reg(REG_INIT_W0, 32'h8000_0000);
		write_reg(REG_INIT_W1, 32'h8000_0000);
		write_reg(REG_INIT_W2, 32'h8000_0000);
		write_reg(REG_INIT_W3, 32'h8000_0000);
		push_item(16'h7FFF, 1'b0, 1'b0);
		push_item(16'h0000, 1'b0, 1'b1);
		wait_idle();

		// random phases, each with fresh register settings
		for (int p = 0; p < 6; p++) begin
			tx_idle_pct = (p < 2) ? 30 : ((p < 4) ? 73 : 0);
			rx_idle_pct = (p < 2) ? 73 : ((p < 4) ? 30 : 0);
			write_reg(REG_RATE, {16'h0, rand_rate()});
			write_reg(REG_MIN_ERR, rand_bound());
			write_reg(REG_INIT_THR, rand_q824());
			write_reg(REG_INIT_W0, rand_q824());
			write_reg(REG_INIT_W1, rand_q824());
			write_reg(REG_INIT_W2, rand_q824());
			write_reg(REG_INIT_W3, rand_q824());
			cnt = 0;
			while (cnt < 290) begin
				// mostly full epochs, now and then one too short to predict
				len = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
				for (int k = 0; k < len; k++)
					push_item(rand_sample(), ($urandom_range(3) != 0), (k == len - 1));
				cnt += len;
			end
			wait_idle();
		end

		if (n_fail == 0 && expected_out.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/lmslp_pkg.sv
rtl/lmslp_ctrl.sv
rtl/lmslp_dp.sv
rtl/lms_linear_predictor.sv
tb/testbench.sv
